/* rtl/core/fdf_pkg.sv */
// Shared types and constants for the four-digit display formatter.
package fdf_pkg;

  // One ASCII character, and the four-character store held units first.
  typedef logic [7:0]       char_t;
  typedef logic [3:0][7:0]  char_quad_t;

  // Digit position on the display, one for units through four for thousands.
  typedef logic [2:0] pos_t;

  // Load result codes.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_LOW  = 2'd1,
    STATUS_HIGH = 2'd2
  } status_t;

  // Beat action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  // Digit positions.
  localparam pos_t POS_UNITS     = 3'd1;
  localparam pos_t POS_TENS      = 3'd2;
  localparam pos_t POS_HUNDREDS  = 3'd3;
  localparam pos_t POS_THOUSANDS = 3'd4;
  localparam pos_t POS_NONE      = 3'd0;

  // Range that can be shown as decimal digits.
  localparam logic signed [15:0] NUM_MIN = -16'sd999;
  localparam logic signed [15:0] NUM_MAX = 16'sd9999;

  // Characters used on the display.
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_BLANK = 8'h20;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_E     = 8'h45;
  localparam char_t CH_R     = 8'h72;
  localparam char_t CH_H     = 8'h68;
  localparam char_t CH_I     = 8'h69;
  localparam char_t CH_L     = 8'h6C;
  localparam char_t CH_O     = 8'h6F;

endpackage

/* rtl/core/four_digit_display_formatter_scan.sv */
// Top level of the four-digit display formatter with scan multiplexer.
// A load beat formats a signed number into four characters (digits with
// blanked leading zeros and a minus sign, or Erlo/Erhi out of range) and
// returns a status; a scan beat returns the latched character and its
// position, then steps to the next position and latches its character.
// Every beat gives exactly one result. The block takes one beat per clock
// cycle while the result is not stalled: an input register feeds the formatter
// and scan logic, whose result lands in an output register. The output
// register is refilled in the same cycle it is emptied, and the input
// register still takes one beat while a finished result waits to be taken.
// in_stall follows out_stall combinationally when both registers are full.
module four_digit_display_formatter_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_shown_char,
  output logic [2:0]         out_digit_position,
  output logic [1:0]         out_status
);

  // Input register.
  logic               in_vld_r;
  logic               act_r;
  logic signed [15:0] num_r;

  // Result register.
  logic                 out_vld_r;
  logic                 out_vld_nxt;
  fdf_pkg::char_t       out_char_r;
  fdf_pkg::char_t       out_char_nxt;
  fdf_pkg::pos_t        out_pos_r;
  fdf_pkg::pos_t        out_pos_nxt;
  fdf_pkg::status_t     out_status_r;
  fdf_pkg::status_t     out_status_nxt;

  // Display state.
  fdf_pkg::char_quad_t  digit_chars_r;
  fdf_pkg::char_quad_t  digit_chars_nxt;
  fdf_pkg::char_t       cur_char_r;
  fdf_pkg::char_t       cur_char_nxt;
  fdf_pkg::pos_t        sel_pos_r;
  fdf_pkg::pos_t        sel_pos_nxt;

  fdf_pkg::char_quad_t  fmt_chars;
  fdf_pkg::status_t     fmt_status;
  logic                 advance;

  // The held beat moves on when the result register is empty or being taken.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  fdf_fmt u_fmt (
    .number (num_r),
    .chars  (fmt_chars),
    .status (fmt_status)
  );

  // Input register capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      act_r <= in_action;
      num_r <= in_number;
    end
  end

  // Result and state update for the beat leaving the input register.
  always_comb begin
    out_vld_nxt     = out_vld_r && out_stall;
    out_char_nxt    = out_char_r;
    out_pos_nxt     = out_pos_r;
    out_status_nxt  = out_status_r;
    digit_chars_nxt = digit_chars_r;
    cur_char_nxt    = cur_char_r;
    sel_pos_nxt     = sel_pos_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
      if (act_r == fdf_pkg::ACT_LOAD) begin
        out_char_nxt    = fdf_pkg::CH_NUL;
        out_pos_nxt     = fdf_pkg::POS_NONE;
        out_status_nxt  = fmt_status;
        digit_chars_nxt = fmt_chars;
      end else begin
        out_char_nxt   = cur_char_r;
        out_pos_nxt    = sel_pos_r;
        out_status_nxt = fdf_pkg::STATUS_OK;
        // Step to the next position; anything past thousands wraps to units.
        unique case (sel_pos_r)
          fdf_pkg::POS_UNITS: begin
            sel_pos_nxt  = fdf_pkg::POS_TENS;
            cur_char_nxt = digit_chars_r[1];
          end
          fdf_pkg::POS_TENS: begin
            sel_pos_nxt  = fdf_pkg::POS_HUNDREDS;
            cur_char_nxt = digit_chars_r[2];
          end
          fdf_pkg::POS_HUNDREDS: begin
            sel_pos_nxt  = fdf_pkg::POS_THOUSANDS;
            cur_char_nxt = digit_chars_r[3];
          end
          default: begin
            sel_pos_nxt  = fdf_pkg::POS_UNITS;
            cur_char_nxt = digit_chars_r[0];
          end
        endcase
      end
    end
  end

  // Control and display state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r     <= 1'b0;
      digit_chars_r <= '0;
      cur_char_r    <= fdf_pkg::CH_NUL;
      sel_pos_r     <= fdf_pkg::POS_UNITS;
    end else begin
      out_vld_r     <= out_vld_nxt;
      digit_chars_r <= digit_chars_nxt;
      cur_char_r    <= cur_char_nxt;
      sel_pos_r     <= sel_pos_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_pos_r    <= out_pos_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_shown_char     = out_char_r;
  assign out_digit_position = out_pos_r;
  assign out_status         = out_status_r;

endmodule

/* rtl/core/fdf_fmt.sv */
// Number-to-characters formatter: range check and decimal digit extraction.
module fdf_fmt (
  input  logic signed [15:0] number,
  output fdf_pkg::char_quad_t chars,
  output fdf_pkg::status_t    status
);

  logic        neg;
  logic [16:0] mag_full;
  logic [13:0] mag;
  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;
  logic [10:0] q1;
  logic [7:0]  q2;
  logic [4:0]  q3;
  logic [13:0] rem0;
  logic [10:0] rem1;
  logic [7:0]  rem2;
  logic [3:0]  d0;
  logic [3:0]  d1;
  logic [3:0]  d2;
  logic [3:0]  d3;

  // Magnitude of the number; only its low 14 bits matter inside the range.
  assign neg      = number[15];
  assign mag_full = neg ? (17'd0 - {number[15], number}) : {number[15], number};
  assign mag      = mag_full[13:0];

  // Quotients by 10, 100 and 1000 through reciprocal multiplication. The
  // three products are independent and exact for every magnitude below 16384.
  assign prod10   = 30'(mag) * 30'd52429;
  assign prod100  = 27'(mag) * 27'd5243;
  assign prod1000 = 28'(mag) * 28'd8389;
  assign q1       = prod10[29:19];
  assign q2       = prod100[26:19];
  assign q3       = prod1000[27:23];

  // Each lower digit is the remainder of one quotient against the next; the thousands digit is the last quotient.
  assign rem0 = mag - (14'(q1) * 14'd10);
  assign rem1 = q1 - (11'(q2) * 11'd10);
  assign rem2 = q2 - (8'(q3) * 8'd10);
  assign d0   = rem0[3:0];
  assign d1   = rem1[3:0];
  assign d2   = rem2[3:0];
  assign d3   = q3[3:0];

  // Character selection: error text out of range, otherwise digits with
  // leading zeros blanked and a minus sign on the thousands place.
  always_comb begin
    if (number < fdf_pkg::NUM_MIN) begin
      chars  = {fdf_pkg::CH_E, fdf_pkg::CH_R, fdf_pkg::CH_L, fdf_pkg::CH_O};
      status = fdf_pkg::STATUS_LOW;
    end else if (number > fdf_pkg::NUM_MAX) begin
      chars  = {fdf_pkg::CH_E, fdf_pkg::CH_R, fdf_pkg::CH_H, fdf_pkg::CH_I};
      status = fdf_pkg::STATUS_HIGH;
    end else begin
      status   = fdf_pkg::STATUS_OK;
      chars[0] = fdf_pkg::CH_ZERO + {4'h0, d0};
      chars[1] = ((d3 | d2 | d1) != 4'h0) ? (fdf_pkg::CH_ZERO + {4'h0, d1})
                                           : fdf_pkg::CH_BLANK;
      chars[2] = ((d3 | d2) != 4'h0) ? (fdf_pkg::CH_ZERO + {4'h0, d2})
                                      : fdf_pkg::CH_BLANK;
      chars[3] = (d3 != 4'h0) ? (fdf_pkg::CH_ZERO + {4'h0, d3}) : fdf_pkg::CH_BLANK;
      if (neg) begin
        chars[3] = fdf_pkg::CH_MINUS;
      end
    end
  end

endmodule

/* dv/display_beat_checker.sv */
// Checker that predicts every display result and compares it with the block's output beats.
module display_beat_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_number,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_shown_char,
  input  logic [2:0]         out_digit_position,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct {
    fdf_pkg::char_t   shown_char;
    fdf_pkg::pos_t    digit_position;
    fdf_pkg::status_t status;
  } display_result_t;

  // Predicted copy of the character store, the latched character and the scan position.
  fdf_pkg::char_quad_t digit_store;
  fdf_pkg::char_t      latched_char;
  fdf_pkg::pos_t       scan_position;
  display_result_t     expected_results[$];

  // Works out the result of one input beat and advances the predicted state.
  function automatic display_result_t predict_beat(input logic action,
                                                   input logic signed [15:0] number);
    display_result_t res;
    int              value;
    int              mag;
    int              d[4];
    res.shown_char     = fdf_pkg::CH_NUL;
    res.digit_position = fdf_pkg::POS_NONE;
    res.status         = fdf_pkg::STATUS_OK;
    value              = number;
    if (action == fdf_pkg::ACT_LOAD) begin
      if (value < fdf_pkg::NUM_MIN) begin
        digit_store = {fdf_pkg::CH_E, fdf_pkg::CH_R, fdf_pkg::CH_L, fdf_pkg::CH_O};
        res.status  = fdf_pkg::STATUS_LOW;
      end else if (value > fdf_pkg::NUM_MAX) begin
        digit_store = {fdf_pkg::CH_E, fdf_pkg::CH_R, fdf_pkg::CH_H, fdf_pkg::CH_I};
        res.status  = fdf_pkg::STATUS_HIGH;
      end else begin
        mag = (value < 0) ? -value : value;
        for (int i = 0; i < 4; i++) begin
          d[i] = mag % 10;
          mag  = mag / 10;
        end
        // Leading zeros are blanked; the units digit is always shown.
        digit_store[0] = 8'(fdf_pkg::CH_ZERO + d[0]);
        digit_store[1] = (d[3] != 0 || d[2] != 0 || d[1] != 0)
                         ? 8'(fdf_pkg::CH_ZERO + d[1]) : fdf_pkg::CH_BLANK;
        digit_store[2] = (d[3] != 0 || d[2] != 0)
                         ? 8'(fdf_pkg::CH_ZERO + d[2]) : fdf_pkg::CH_BLANK;
        digit_store[3] = (d[3] != 0) ? 8'(fdf_pkg::CH_ZERO + d[3]) : fdf_pkg::CH_BLANK;
        if (value < 0) begin
          digit_store[3] = fdf_pkg::CH_MINUS;
        end
      end
    end else begin
      res.shown_char     = latched_char;
      res.digit_position = scan_position;
      // Step to the next position and latch its character; anything odd wraps to units.
      case (scan_position)
        fdf_pkg::POS_UNITS: begin
          scan_position = fdf_pkg::POS_TENS;
          latched_char  = digit_store[1];
        end
        fdf_pkg::POS_TENS: begin
          scan_position = fdf_pkg::POS_HUNDREDS;
          latched_char  = digit_store[2];
        end
        fdf_pkg::POS_HUNDREDS: begin
          scan_position = fdf_pkg::POS_THOUSANDS;
          latched_char  = digit_store[3];
        end
        default: begin
          scan_position = fdf_pkg::POS_UNITS;
          latched_char  = digit_store[0];
        end
      endcase
    end
    return res;
  endfunction

  // Results are checked before new beats are queued, so a stray result is never masked.
  always @(posedge clk) begin
    display_result_t want;
    if (!rst_n) begin
      digit_store   = '0;
      latched_char  = fdf_pkg::CH_NUL;
      scan_position = fdf_pkg::POS_UNITS;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting: char %h pos %0d status %0d",
                 out_shown_char, out_digit_position, out_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_shown_char !== want.shown_char) begin
            $error("shown_char: expected %h, got %h", want.shown_char, out_shown_char);
            fail_count++;
          end
          if (out_digit_position !== want.digit_position) begin
            $error("digit_position: expected %0d, got %0d",
                   want.digit_position, out_digit_position);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_beat(in_action, in_number));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top: drives load and scan beats into the display formatter and gives the verdict.
module tb_top;

  localparam int CYCLE_LIMIT    = 500_000;
  localparam int RANDOM_BEATS   = 1550;
  localparam int HOLD_OFF_BEATS = 400;
  localparam int HOLD_OFF_LEN   = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic signed [15:0] in_number;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_shown_char;
  logic [2:0]         out_digit_position;
  logic [1:0]         out_status;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count;
  int                 beats_sent;
  bit                 hold_off_req;
  bit                 hold_off_done;

  four_digit_display_formatter_scan u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_number          (in_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shown_char     (out_shown_char),
    .out_digit_position (out_digit_position),
    .out_status         (out_status)
  );

  display_beat_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_number          (in_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shown_char     (out_shown_char),
    .out_digit_position (out_digit_position),
    .out_status         (out_status),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Pause length shared by both sides: mostly none or short, now and then long.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Load values weighted towards the range edges, small numbers and negatives.
  function automatic logic signed [15:0] pick_number();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(0, 10998) - 999);
      4:          return 16'($urandom_range(0, 40) - 20);
      5:          return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 4) - 1001)
                                                     : 16'($urandom_range(9997, 10001));
      6, 7:       return 16'($urandom_range(0, 16'hFFFF));
      8:          return 16'(-$urandom_range(1, 999));
      default:    return 16'($urandom_range(0, 99));
    endcase
  endfunction

  // Offers one beat after an optional gap and returns at the edge where it is taken.
  task automatic send_beat(input logic action, input logic signed [15:0] number,
                           input bit quiet = 1'b0);
    int gap;
    gap = quiet ? 0 : pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= action;
    in_number <= number;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (beats_sent == HOLD_OFF_BEATS) begin
      hold_off_req = 1'b1;
    end
  endtask

  // Receiver: free runs and stalls of random length, with one long hold-off.
  initial begin
    int free_len;
    int stall_len;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        @(posedge clk);
        out_stall <= 1'b1;
        for (int n = 1; n < HOLD_OFF_LEN; n++) @(posedge clk);
        hold_off_done = 1'b1;
      end
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      @(posedge clk);
      out_stall <= 1'b0;
      repeat (free_len - 1) @(posedge clk);
      stall_len = pick_pause();
      if (stall_len > 0) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (stall_len - 1) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int  scans;
    bit  quiet;
    beats_sent    = 0;
    hold_off_req  = 1'b0;
    hold_off_done = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_action <= fdf_pkg::ACT_LOAD;
    in_number <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: scans of the cleared store, zero, the range edges, both error
    // texts, the field extremes, negatives with a minus sign and blanked leading zeros.
    send_beat(fdf_pkg::ACT_SCAN, 16'sd0);
    send_beat(fdf_pkg::ACT_SCAN, -16'sd1);
    send_beat(fdf_pkg::ACT_LOAD, 16'sd0);
    repeat (4) send_beat(fdf_pkg::ACT_SCAN, 16'sd0);
    send_beat(fdf_pkg::ACT_LOAD, 16'sd9999);
    send_beat(fdf_pkg::ACT_LOAD, 16'sd10000);
    send_beat(fdf_pkg::ACT_SCAN, 16'sd0);
    send_beat(fdf_pkg::ACT_SCAN, 16'sd0);
    send_beat(fdf_pkg::ACT_LOAD, -16'sd999);
    repeat (4) send_beat(fdf_pkg::ACT_SCAN, 16'sd0);
    send_beat(fdf_pkg::ACT_LOAD, -16'sd1000);
    send_beat(fdf_pkg::ACT_LOAD, -16'sd32768);
    send_beat(fdf_pkg::ACT_LOAD, 16'sd32767);
    send_beat(fdf_pkg::ACT_LOAD, -16'sd50);
    send_beat(fdf_pkg::ACT_LOAD, 16'sd7);
    send_beat(fdf_pkg::ACT_LOAD, 16'sd42);
    send_beat(fdf_pkg::ACT_LOAD, 16'sd305);
    send_beat(fdf_pkg::ACT_SCAN, 16'sd0);
    send_beat(fdf_pkg::ACT_SCAN, 16'sd0);

    // Random part: mostly a load followed by a run of scans, the rest single noise beats.
    // Every fourth block of a hundred beats is offered without gaps.
    while (beats_sent < RANDOM_BEATS) begin
      quiet = ((beats_sent / 100) % 4) == 3;
      if ($urandom_range(0, 9) < 7) begin
        send_beat(fdf_pkg::ACT_LOAD, pick_number(), quiet);
        scans = $urandom_range(3, 9);
        repeat (scans) send_beat(fdf_pkg::ACT_SCAN, 16'($urandom_range(0, 16'hFFFF)), quiet);
      end else begin
        send_beat(logic'($urandom_range(0, 1)), pick_number(), quiet);
      end
    end
    in_valid <= 1'b0;

    // Drain every expected result, then keep watching for anything stray before the verdict.
    do @(posedge clk); while (pending_count != 0);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
